// ===== hw/rtl/lavm_pkg.sv =====
// look-at view matrix: shared widths and types
// used by lavm_norm and look_at_view_matrix, no dependencies
package lavm_pkg;

    localparam int COORD_W = 32;
    localparam int FRAC_W  = 16;
    localparam int NORM_W  = 31;
    localparam int UNIT_W  = FRAC_W + 2;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = FRAC_W + 1;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [UNIT_W-1:0]  unit_t;

endpackage

// ===== hw/rtl/lavm_norm.sv =====
// pipelined 3-vector normalizer: scale, sum of squares, square root, divide
// depends on lavm_pkg
module lavm_norm #(
    parameter int IN_W   = 50,
    parameter int SIDE_W = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic signed [IN_W-1:0]        in_c [3],
    input  logic [SIDE_W-1:0]             in_side,
    output logic                          out_valid,
    output logic signed [lavm_pkg::UNIT_W-1:0] out_o [3],
    output logic [SIDE_W-1:0]             out_side
);
    import lavm_pkg::*;

    localparam int PW    = $clog2(IN_W);
    localparam int SQ_W  = 2 * NORM_W;
    localparam int REM_W = NORM_W + FRAC_W + 2;
    localparam int LEN_W = SQRT_STEPS;

    typedef struct packed {
        logic [2:0][NORM_W-1:0] mag;
        logic [2:0]             neg;
        logic                   zero;
        logic [SIDE_W-1:0]      side;
    } carry_t;

    // stage a: magnitudes
    logic [IN_W-1:0]   mag_a_reg [3];
    logic [IN_W-1:0]   mag_a_next [3];
    logic [2:0]        neg_a_reg, neg_a_next;
    logic [SIDE_W-1:0] side_a_reg;
    logic              valid_a_reg;
    // stage b: leading one
    logic [IN_W-1:0]   mag_b_reg [3];
    logic [PW-1:0]     pos_b_reg, pos_b_next;
    logic              zero_b_reg, zero_b_next;
    logic [2:0]        neg_b_reg;
    logic [SIDE_W-1:0] side_b_reg;
    logic              valid_b_reg;
    // stage c: scaled, stage d: squares
    carry_t            car_c_reg, car_c_next, car_d_reg;
    logic              valid_c_reg, valid_d_reg;
    logic [SQ_W-1:0]   sq_d_reg [3];
    logic [SQ_W-1:0]   sq_d_next [3];
    // square root steps
    logic [63:0]       rt_s_reg [SQRT_STEPS+1];
    logic [63:0]       rt_s_next [SQRT_STEPS+1];
    logic [63:0]       rt_r_reg [SQRT_STEPS+1];
    logic [63:0]       rt_r_next [SQRT_STEPS+1];
    carry_t            rt_car_reg [SQRT_STEPS+1];
    logic              rt_valid_reg [SQRT_STEPS+1];
    // divide steps
    logic [REM_W-1:0]   dv_rem_reg [DIV_STEPS+1][3];
    logic [REM_W-1:0]   dv_rem_next [DIV_STEPS+1][3];
    logic [DIV_STEPS-1:0] dv_q_reg [DIV_STEPS+1][3];
    logic [DIV_STEPS-1:0] dv_q_next [DIV_STEPS+1][3];
    logic [LEN_W-1:0]   dv_len_reg [DIV_STEPS+1];
    carry_t             dv_car_reg [DIV_STEPS+1];
    logic               dv_valid_reg [DIV_STEPS+1];
    // output
    unit_t              o_reg [3];
    unit_t              o_next [3];
    logic [SIDE_W-1:0]  oside_reg;
    logic               ovalid_reg;

    always_comb
    begin
        logic [IN_W-1:0]        orall;
        logic [IN_W+NORM_W-1:0] wide;
        logic [63:0]            bitv;
        logic [63:0]            trial;
        logic [REM_W-1:0]       dvs;
        logic [DIV_STEPS-1:0]   qa;
        orall = '0;
        wide  = '0;
        bitv  = '0;
        trial = '0;
        dvs   = '0;
        qa    = '0;
        for (int i = 0; i < 3; i++)
        begin
            neg_a_next[i] = in_c[i][IN_W-1];
            mag_a_next[i] = in_c[i][IN_W-1] ? IN_W'(-in_c[i]) : IN_W'(in_c[i]);
        end
        orall = mag_a_reg[0] | mag_a_reg[1] | mag_a_reg[2];
        zero_b_next = (orall == '0);
        pos_b_next  = '0;
        for (int b = 0; b < IN_W; b++)
        begin
            if (orall[b])
                pos_b_next = PW'(b);
        end
        car_c_next.neg  = neg_b_reg;
        car_c_next.zero = zero_b_reg;
        car_c_next.side = side_b_reg;
        for (int i = 0; i < 3; i++)
        begin
            wide = {{NORM_W{1'b0}}, mag_b_reg[i]};
            if (pos_b_reg >= PW'(NORM_W - 1))
                wide = wide >> (pos_b_reg - PW'(NORM_W - 1));
            else
                wide = wide << (PW'(NORM_W - 1) - pos_b_reg);
            car_c_next.mag[i] = wide[NORM_W-1:0];
        end
        for (int i = 0; i < 3; i++)
            sq_d_next[i] = SQ_W'(car_c_reg.mag[i]) * SQ_W'(car_c_reg.mag[i]);
        rt_s_next[0] = 64'(sq_d_reg[0]) + 64'(sq_d_reg[1]) + 64'(sq_d_reg[2]);
        rt_r_next[0] = '0;
        for (int k = 0; k < SQRT_STEPS; k++)
        begin
            bitv  = 64'd1 << (62 - 2 * k);
            trial = rt_r_reg[k] + bitv;
            if (rt_s_reg[k] >= trial)
            begin
                rt_s_next[k+1] = rt_s_reg[k] - trial;
                rt_r_next[k+1] = (rt_r_reg[k] >> 1) + bitv;
            end
            else
            begin
                rt_s_next[k+1] = rt_s_reg[k];
                rt_r_next[k+1] = rt_r_reg[k] >> 1;
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            dv_rem_next[0][i] = (REM_W'(rt_car_reg[SQRT_STEPS].mag[i]) << FRAC_W)
                + REM_W'(rt_r_reg[SQRT_STEPS][LEN_W-1:1]);
            dv_q_next[0][i] = '0;
        end
        for (int j = 0; j < DIV_STEPS; j++)
        begin
            dvs = REM_W'(dv_len_reg[j]) << (DIV_STEPS - 1 - j);
            for (int i = 0; i < 3; i++)
            begin
                if (dv_rem_reg[j][i] >= dvs)
                begin
                    dv_rem_next[j+1][i] = dv_rem_reg[j][i] - dvs;
                    dv_q_next[j+1][i] = dv_q_reg[j][i]
                        | (DIV_STEPS'(1) << (DIV_STEPS - 1 - j));
                end
                else
                begin
                    dv_rem_next[j+1][i] = dv_rem_reg[j][i];
                    dv_q_next[j+1][i] = dv_q_reg[j][i];
                end
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            qa = dv_q_reg[DIV_STEPS][i];
            if (dv_car_reg[DIV_STEPS].zero)
                o_next[i] = '0;
            else if (dv_car_reg[DIV_STEPS].neg[i])
                o_next[i] = -$signed(UNIT_W'(qa));
            else
                o_next[i] = $signed(UNIT_W'(qa));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
            valid_c_reg <= 1'b0;
            valid_d_reg <= 1'b0;
            for (int k = 0; k <= SQRT_STEPS; k++)
                rt_valid_reg[k] <= 1'b0;
            for (int j = 0; j <= DIV_STEPS; j++)
                dv_valid_reg[j] <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_a_reg <= in_valid;
            valid_b_reg <= valid_a_reg;
            valid_c_reg <= valid_b_reg;
            valid_d_reg <= valid_c_reg;
            rt_valid_reg[0] <= valid_d_reg;
            for (int k = 0; k < SQRT_STEPS; k++)
                rt_valid_reg[k+1] <= rt_valid_reg[k];
            dv_valid_reg[0] <= rt_valid_reg[SQRT_STEPS];
            for (int j = 0; j < DIV_STEPS; j++)
                dv_valid_reg[j+1] <= dv_valid_reg[j];
            ovalid_reg <= dv_valid_reg[DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_a_reg  <= mag_a_next;
            neg_a_reg  <= neg_a_next;
            side_a_reg <= in_side;
            mag_b_reg  <= mag_a_reg;
            pos_b_reg  <= pos_b_next;
            zero_b_reg <= zero_b_next;
            neg_b_reg  <= neg_a_reg;
            side_b_reg <= side_a_reg;
            car_c_reg  <= car_c_next;
            car_d_reg  <= car_c_reg;
            sq_d_reg   <= sq_d_next;
            rt_s_reg   <= rt_s_next;
            rt_r_reg   <= rt_r_next;
            rt_car_reg[0] <= car_d_reg;
            for (int k = 0; k < SQRT_STEPS; k++)
                rt_car_reg[k+1] <= rt_car_reg[k];
            dv_rem_reg <= dv_rem_next;
            dv_q_reg   <= dv_q_next;
            dv_len_reg[0] <= rt_r_reg[SQRT_STEPS][LEN_W-1:0];
            dv_car_reg[0] <= rt_car_reg[SQRT_STEPS];
            for (int j = 0; j < DIV_STEPS; j++)
            begin
                dv_len_reg[j+1] <= dv_len_reg[j];
                dv_car_reg[j+1] <= dv_car_reg[j];
            end
            o_reg     <= o_next;
            oside_reg <= dv_car_reg[DIV_STEPS].side;
        end
    end

    assign out_valid = ovalid_reg;
    assign out_o     = o_reg;
    assign out_side  = oside_reg;

endmodule

// ===== hw/rtl/look_at_view_matrix.sv =====
// Look-at view matrix, fixed point Q16.16, fully pipelined. One pose is taken
// each cycle while the result side does not stall. A pose passes 118 register
// stages: the two normalizers of 56 stages each (4 input stages, 33 square root
// stages, 18 divide stages and an output register) plus six stages of products
// and sums. A stall on the result side holds every stage.
// depends on lavm_pkg and lavm_norm
module look_at_view_matrix (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z
    input  logic [287:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // basis_u_x/y/z, basis_v_x/y/z, basis_w_x/y/z, shift_u, shift_v, shift_w
    output logic [383:0] m_tdata
);
    import lavm_pkg::*;

    localparam int D_W    = COORD_W + 1;
    localparam int CP_W   = COORD_W + UNIT_W;
    localparam int V_W    = UNIT_W + 2;
    localparam int VP_W   = 2 * UNIT_W;
    localparam int DOT_W  = COORD_W + V_W + 3;
    localparam int SIDE1_W = 6 * COORD_W;
    localparam int SIDE2_W = 3 * COORD_W + 3 * UNIT_W;

    logic adv;
    coord_t eye_in [3];
    coord_t up_in [3];
    logic signed [D_W-1:0] d_in [3];

    logic n1_valid;
    unit_t n1_w [3];
    logic [SIDE1_W-1:0] n1_side;

    logic t1_valid_reg;
    logic signed [CP_W-1:0] pa_reg [3];
    logic signed [CP_W-1:0] pb_reg [3];
    coord_t eye1_reg [3];
    unit_t w1_reg [3];
    logic signed [CP_W-1:0] cu_in [3];

    logic n2_valid;
    unit_t n2_u [3];
    logic [SIDE2_W-1:0] n2_side;
    unit_t w2 [3];
    coord_t eye2 [3];

    logic t3_valid_reg;
    logic signed [VP_W-1:0] vpa_reg [3];
    logic signed [VP_W-1:0] vpb_reg [3];
    logic signed [CP_W-1:0] du_reg [3];
    logic signed [CP_W-1:0] dw_reg [3];
    unit_t u3_reg [3];
    unit_t w3_reg [3];
    coord_t eye3_reg [3];

    logic t4_valid_reg;
    logic signed [V_W-1:0] v4_reg [3];
    logic signed [V_W-1:0] v4_next [3];
    logic signed [DOT_W-1:0] su4_reg, sw4_reg;
    unit_t u4_reg [3];
    unit_t w4_reg [3];
    coord_t eye4_reg [3];

    logic t5_valid_reg;
    logic signed [COORD_W+V_W-1:0] dv5_reg [3];
    logic signed [DOT_W-1:0] su5_reg, sw5_reg;
    logic signed [V_W-1:0] v5_reg [3];
    unit_t u5_reg [3];
    unit_t w5_reg [3];

    logic t6_valid_reg;
    logic signed [DOT_W-1:0] su6_reg, sv6_reg, sw6_reg;
    logic signed [V_W-1:0] v6_reg [3];
    unit_t u6_reg [3];
    unit_t w6_reg [3];

    logic out_valid_reg;
    coord_t bu_reg [3];
    coord_t bv_reg [3];
    coord_t bw_reg [3];
    coord_t sh_reg [3];

    function automatic coord_t round_sat(input logic signed [DOT_W-1:0] dot);
        logic signed [DOT_W+1:0] t;
        logic signed [DOT_W+1:0] r;
        t = (DOT_W+2)'(32768) - (DOT_W+2)'(dot);
        r = t >>> FRAC_W;
        if (r > (DOT_W+2)'(64'sd2147483647))
            round_sat = 32'sh7fffffff;
        else if (r < -(DOT_W+2)'(64'sd2147483648))
            round_sat = 32'sh80000000;
        else
            round_sat = r[COORD_W-1:0];
    endfunction

    assign adv = !out_valid_reg || m_tready;
    assign s_tready = adv;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            eye_in[i] = $signed(s_tdata[COORD_W*i +: COORD_W]);
            up_in[i]  = $signed(s_tdata[COORD_W*(i+6) +: COORD_W]);
            d_in[i]   = D_W'(eye_in[i]) - D_W'($signed(s_tdata[COORD_W*(i+3) +: COORD_W]));
        end
    end

    lavm_norm #(.IN_W(D_W), .SIDE_W(SIDE1_W)) u_norm_w (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s_tvalid),
        .in_c      (d_in),
        .in_side   ({up_in[2], up_in[1], up_in[0], eye_in[2], eye_in[1], eye_in[0]}),
        .out_valid (n1_valid),
        .out_o     (n1_w),
        .out_side  (n1_side)
    );

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            cu_in[i] = pa_reg[i] - pb_reg[i];
    end

    lavm_norm #(.IN_W(CP_W), .SIDE_W(SIDE2_W)) u_norm_u (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (t1_valid_reg),
        .in_c      (cu_in),
        .in_side   ({w1_reg[2], w1_reg[1], w1_reg[0], eye1_reg[2], eye1_reg[1], eye1_reg[0]}),
        .out_valid (n2_valid),
        .out_o     (n2_u),
        .out_side  (n2_side)
    );

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            eye2[i] = $signed(n2_side[COORD_W*i +: COORD_W]);
            w2[i]   = $signed(n2_side[3*COORD_W + UNIT_W*i +: UNIT_W]);
            v4_next[i] = V_W'((VP_W'(vpa_reg[i]) - VP_W'(vpb_reg[i])
                + (VP_W+1)'(32768)) >>> FRAC_W);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_valid_reg  <= 1'b0;
            t3_valid_reg  <= 1'b0;
            t4_valid_reg  <= 1'b0;
            t5_valid_reg  <= 1'b0;
            t6_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            t1_valid_reg  <= n1_valid;
            t3_valid_reg  <= n2_valid;
            t4_valid_reg  <= t3_valid_reg;
            t5_valid_reg  <= t4_valid_reg;
            t6_valid_reg  <= t5_valid_reg;
            out_valid_reg <= t6_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // up cross w
            for (int i = 0; i < 3; i++)
            begin
                eye1_reg[i] <= $signed(n1_side[COORD_W*i +: COORD_W]);
                w1_reg[i]   <= n1_w[i];
            end
            pa_reg[0] <= $signed(n1_side[COORD_W*4 +: COORD_W]) * n1_w[2];
            pb_reg[0] <= $signed(n1_side[COORD_W*5 +: COORD_W]) * n1_w[1];
            pa_reg[1] <= $signed(n1_side[COORD_W*5 +: COORD_W]) * n1_w[0];
            pb_reg[1] <= $signed(n1_side[COORD_W*3 +: COORD_W]) * n1_w[2];
            pa_reg[2] <= $signed(n1_side[COORD_W*3 +: COORD_W]) * n1_w[1];
            pb_reg[2] <= $signed(n1_side[COORD_W*4 +: COORD_W]) * n1_w[0];
            // w cross u and the dots with eye
            vpa_reg[0] <= w2[1] * n2_u[2];
            vpb_reg[0] <= w2[2] * n2_u[1];
            vpa_reg[1] <= w2[2] * n2_u[0];
            vpb_reg[1] <= w2[0] * n2_u[2];
            vpa_reg[2] <= w2[0] * n2_u[1];
            vpb_reg[2] <= w2[1] * n2_u[0];
            for (int i = 0; i < 3; i++)
            begin
                du_reg[i]   <= eye2[i] * n2_u[i];
                dw_reg[i]   <= eye2[i] * w2[i];
                u3_reg[i]   <= n2_u[i];
                w3_reg[i]   <= w2[i];
                eye3_reg[i] <= eye2[i];
            end
            su4_reg <= DOT_W'(du_reg[0]) + DOT_W'(du_reg[1]) + DOT_W'(du_reg[2]);
            sw4_reg <= DOT_W'(dw_reg[0]) + DOT_W'(dw_reg[1]) + DOT_W'(dw_reg[2]);
            v4_reg  <= v4_next;
            u4_reg  <= u3_reg;
            w4_reg  <= w3_reg;
            eye4_reg <= eye3_reg;
            for (int i = 0; i < 3; i++)
                dv5_reg[i] <= eye4_reg[i] * v4_reg[i];
            su5_reg <= su4_reg;
            sw5_reg <= sw4_reg;
            v5_reg  <= v4_reg;
            u5_reg  <= u4_reg;
            w5_reg  <= w4_reg;
            sv6_reg <= DOT_W'(dv5_reg[0]) + DOT_W'(dv5_reg[1]) + DOT_W'(dv5_reg[2]);
            su6_reg <= su5_reg;
            sw6_reg <= sw5_reg;
            v6_reg  <= v5_reg;
            u6_reg  <= u5_reg;
            w6_reg  <= w5_reg;
            for (int i = 0; i < 3; i++)
            begin
                bu_reg[i] <= COORD_W'(u6_reg[i]);
                bv_reg[i] <= COORD_W'(v6_reg[i]);
                bw_reg[i] <= COORD_W'(w6_reg[i]);
            end
            sh_reg[0] <= round_sat(su6_reg);
            sh_reg[1] <= round_sat(sv6_reg);
            sh_reg[2] <= round_sat(sw6_reg);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {sh_reg[2], sh_reg[1], sh_reg[0],
                       bw_reg[2], bw_reg[1], bw_reg[0],
                       bv_reg[2], bv_reg[1], bv_reg[0],
                       bu_reg[2], bu_reg[1], bu_reg[0]};

`ifndef SYNTHESIS
    ap_w_zero_u_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && bw_reg[0] == 0 && bw_reg[1] == 0 && bw_reg[2] == 0
        |-> bu_reg[0] == 0 && bu_reg[1] == 0 && bu_reg[2] == 0)
        else $error("u not zero for zero w");

    ap_u_zero_v_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && bu_reg[0] == 0 && bu_reg[1] == 0 && bu_reg[2] == 0
        |-> bv_reg[0] == 0 && bv_reg[1] == 0 && bv_reg[2] == 0
            && sh_reg[0] == 0 && sh_reg[1] == 0)
        else $error("v or shifts not zero for zero u");

    ap_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> bw_reg[0] <= 65536 && bw_reg[0] >= -65536
            && bu_reg[0] <= 65536 && bu_reg[0] >= -65536)
        else $error("unit component out of range");
`endif

endmodule
